// ===== rtl/dlq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_pkg
// Shared types and constants of the debounced level qualifier.
// ----------------------------------------------------------------------------
package dlq_pkg;

	localparam int DataW   = 32;
	localparam int DebW    = 16;
	localparam int CfgIdxW = 2;
	localparam int QDepth  = 2;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_MATCHED = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MATCH_LEVEL = 2'd2;

	typedef enum logic [2:0] {
		EV_REPEAT   = 3'd0,
		EV_MATCH    = 3'd1,
		EV_UNMATCH  = 3'd2,
		EV_BOUNCE   = 3'd3,
		EV_OVERLONG = 3'd4
	} event_t;

	typedef struct packed {
		event_t            ev;
		logic [DataW-1:0]  elapsed;
	} cmd_t;

	typedef struct packed {
		logic [DebW-1:0]   debounce_ms;
		logic [DataW-1:0]  max_matched_ms;
		logic              match_level;
	} cfg_t;

endpackage

// ===== rtl/debounced_level_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_level_qualifier
// Qualifies pin-change events against a debounce time and a maximum matched
// pulse width, and reports an event code with running counters.
// ----------------------------------------------------------------------------
// Each request is one pin event (level and millisecond timestamp) and yields
// exactly one result. The block takes one request per clock while in_stall is
// low; a request passes the queue and then the output register. A two-entry
// queue between the classifier and the counter stage absorbs output stalls, so
// in_stall rises only when two requests wait behind a stalled result. The user
// must write configuration through cfg_we, cfg_index and cfg_data only while
// idle, which is not enforced; an index beyond the three registers is ignored.
module debounced_level_qualifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dlq_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [dlq_pkg::DataW-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        level,
	input  logic [dlq_pkg::DataW-1:0]   now_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  event_res,
	output logic                        matched,
	output logic [dlq_pkg::DataW-1:0]   invoked_count,
	output logic [dlq_pkg::DataW-1:0]   repeat_count,
	output logic [dlq_pkg::DataW-1:0]   match_count,
	output logic [dlq_pkg::DataW-1:0]   unmatch_count,
	output logic [dlq_pkg::DataW-1:0]   spurious_count,
	output logic [dlq_pkg::DataW-1:0]   last_duration
);

	dlq_pkg::cfg_t cfg_q;
	dlq_pkg::cmd_t push_cmd;
	dlq_pkg::cmd_t head_cmd;
	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= dlq_pkg::DebW'(50);
			cfg_q.max_matched_ms <= '0;
			cfg_q.match_level    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlq_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data[dlq_pkg::DebW-1:0];
				end
				dlq_pkg::REG_MAX_MATCHED: begin
					cfg_q.max_matched_ms <= cfg_data;
				end
				dlq_pkg::REG_MATCH_LEVEL: begin
					cfg_q.match_level <= cfg_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	dlq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.level    (level),
		.now_ms   (now_ms),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	dlq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	dlq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_head         (head_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.matched        (matched),
		.invoked_count  (invoked_count),
		.repeat_count   (repeat_count),
		.match_count    (match_count),
		.unmatch_count  (unmatch_count),
		.spurious_count (spurious_count),
		.last_duration  (last_duration)
	);

endmodule

// ===== rtl/dlq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_front
// Accepts pin events, tracks the last level and change time, and classifies
// each event into a command for the back end.
// ----------------------------------------------------------------------------
module dlq_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dlq_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      level,
	input  logic [dlq_pkg::DataW-1:0] now_ms,
	input  logic                      q_full,
	output logic                      q_push,
	output dlq_pkg::cmd_t             q_cmd
);

	logic                      prev_level_q;
	logic [dlq_pkg::DataW-1:0] change_time_q;
	logic [dlq_pkg::DataW-1:0] elapsed;
	logic                      is_repeat;
	logic                      settled;
	logic                      within_max;
	dlq_pkg::event_t           ev;

	assign in_stall   = q_full;
	assign q_push     = in_valid & ~q_full;
	assign elapsed    = now_ms - change_time_q;
	assign is_repeat  = (level == prev_level_q);
	assign settled    = (elapsed >= {{(dlq_pkg::DataW - dlq_pkg::DebW){1'b0}}, cfg.debounce_ms});
	assign within_max = (cfg.max_matched_ms == '0) || (elapsed < cfg.max_matched_ms);

	always_comb begin
		priority if (is_repeat) begin
			ev = dlq_pkg::EV_REPEAT;
		end else if (!settled) begin
			ev = dlq_pkg::EV_BOUNCE;
		end else if (level == cfg.match_level) begin
			ev = dlq_pkg::EV_MATCH;
		end else if (within_max) begin
			ev = dlq_pkg::EV_UNMATCH;
		end else begin
			ev = dlq_pkg::EV_OVERLONG;
		end
	end

	assign q_cmd.ev      = ev;
	assign q_cmd.elapsed = elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= 1'b0;
			change_time_q <= '0;
		end else if (q_push && !is_repeat) begin
			prev_level_q  <= level;
			change_time_q <= now_ms;
		end
	end

endmodule

// ===== rtl/dlq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_queue
// Short request queue between the classifier and the counter back end.
// ----------------------------------------------------------------------------
module dlq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dlq_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output dlq_pkg::cmd_t head
);

	dlq_pkg::cmd_t                  mem_q [dlq_pkg::QDepth];
	logic [dlq_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [dlq_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [dlq_pkg::QCntW-1:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	localparam logic [dlq_pkg::QPtrW-1:0] LastPtr = dlq_pkg::QPtrW'(dlq_pkg::QDepth - 1);
	localparam logic [dlq_pkg::QCntW-1:0] FullCnt = dlq_pkg::QCntW'(dlq_pkg::QDepth);

	assign full      = (count_q == FullCnt);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/dlq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_back
// Applies classified requests to the matched state and the event counters
// and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module dlq_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_not_empty,
	input  dlq_pkg::cmd_t             q_head,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                event_res,
	output logic                      matched,
	output logic [dlq_pkg::DataW-1:0] invoked_count,
	output logic [dlq_pkg::DataW-1:0] repeat_count,
	output logic [dlq_pkg::DataW-1:0] match_count,
	output logic [dlq_pkg::DataW-1:0] unmatch_count,
	output logic [dlq_pkg::DataW-1:0] spurious_count,
	output logic [dlq_pkg::DataW-1:0] last_duration
);

	logic                      out_valid_q;
	dlq_pkg::event_t           ev_q;
	logic                      matched_q;
	logic [dlq_pkg::DataW-1:0] events_q;
	logic [dlq_pkg::DataW-1:0] repeats_q;
	logic [dlq_pkg::DataW-1:0] matches_q;
	logic [dlq_pkg::DataW-1:0] unmatches_q;
	logic [dlq_pkg::DataW-1:0] spurious_q;
	logic [dlq_pkg::DataW-1:0] duration_q;

	assign q_pop = q_not_empty & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ev_q        <= dlq_pkg::EV_REPEAT;
			matched_q   <= 1'b0;
			events_q    <= '0;
			repeats_q   <= '0;
			matches_q   <= '0;
			unmatches_q <= '0;
			spurious_q  <= '0;
			duration_q  <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				ev_q     <= q_head.ev;
				events_q <= events_q + 1'b1;
				unique case (q_head.ev)
					dlq_pkg::EV_REPEAT: begin
						repeats_q <= repeats_q + 1'b1;
					end
					dlq_pkg::EV_MATCH: begin
						matches_q <= matches_q + 1'b1;
						matched_q <= 1'b1;
					end
					dlq_pkg::EV_UNMATCH: begin
						unmatches_q <= unmatches_q + 1'b1;
						duration_q  <= q_head.elapsed;
						matched_q   <= 1'b0;
					end
					dlq_pkg::EV_BOUNCE: begin
						spurious_q <= spurious_q + 1'b1;
					end
					dlq_pkg::EV_OVERLONG: begin
						spurious_q <= spurious_q + 1'b1;
						matched_q  <= 1'b0;
					end
					default: begin
						spurious_q <= spurious_q;
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = ev_q;
	assign matched        = matched_q;
	assign invoked_count  = events_q;
	assign repeat_count   = repeats_q;
	assign match_count    = matches_q;
	assign unmatch_count  = unmatches_q;
	assign spurious_count = spurious_q;
	assign last_duration  = duration_q;

endmodule

// ===== dv/debounced_level_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_level_qualifier_tb
// Self-checking bench for the debounced level qualifier. A short table of pin
// events walks through the debounce and pulse-width corner cases, then eight
// randomized phases with different register settings follow. Each request is
// scored against a built-in model of the qualifier, under random idling on
// both channels, a long output hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module debounced_level_qualifier_tb;
	import dlq_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASE_EVENTS = 100;

	typedef struct packed {
		event_t           ev;
		logic             matched;
		logic [DataW-1:0] invoked;
		logic [DataW-1:0] repeats;
		logic [DataW-1:0] match_cnt;
		logic [DataW-1:0] unmatches;
		logic [DataW-1:0] spurious;
		logic [DataW-1:0] duration;
	} qual_res_t;

	typedef struct packed {
		logic   typed;
		event_t ev;
		logic   matched;
	} ev_tag_t;

	typedef struct {
		logic               is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [DataW-1:0]   data;
		logic               lvl;
		logic [DataW-1:0]   stamp;
		ev_tag_t            tag;
	} pin_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [DataW-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               level = 1'b0;
	logic [DataW-1:0]   now_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         event_res;
	logic               matched;
	logic [DataW-1:0]   invoked_count;
	logic [DataW-1:0]   repeat_count;
	logic [DataW-1:0]   match_count;
	logic [DataW-1:0]   unmatch_count;
	logic [DataW-1:0]   spurious_count;
	logic [DataW-1:0]   last_duration;

	// Model copy of the registers and of the qualifier state.
	logic [DebW-1:0]  m_debounce = 16'd50;
	logic [DataW-1:0] m_max_matched = '0;
	logic             m_match_level = 1'b0;
	logic             m_prev_level = 1'b0;
	logic [DataW-1:0] m_change_time = '0;
	logic             m_matched = 1'b0;
	logic [DataW-1:0] m_events = '0;
	logic [DataW-1:0] m_repeats = '0;
	logic [DataW-1:0] m_matches = '0;
	logic [DataW-1:0] m_unmatches = '0;
	logic [DataW-1:0] m_spurious = '0;
	logic [DataW-1:0] m_duration = '0;

	qual_res_t pending_quals[$];
	ev_tag_t   event_tags[$];
	pin_row_t  pin_table[$];
	int        events_sent = 0;
	int        quals_checked = 0;
	int        errors = 0;
	int        quiet_cycles = 0;
	bit        idle_on = 1'b1;
	bit        stall_on = 1'b1;
	bit        hold_req = 1'b0;
	logic             send_lvl = 1'b0;
	logic [DataW-1:0] send_stamp = '0;

	debounced_level_qualifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.level(level),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.matched(matched),
		.invoked_count(invoked_count),
		.repeat_count(repeat_count),
		.match_count(match_count),
		.unmatch_count(unmatch_count),
		.spurious_count(spurious_count),
		.last_duration(last_duration)
	);

	always #10 clk = ~clk;

	function automatic qual_res_t qualify_event(input logic lvl, input logic [DataW-1:0] stamp);
		qual_res_t res;
		logic [DataW-1:0] elapsed;
		elapsed = stamp - m_change_time;
		m_events = m_events + 1;
		if (lvl == m_prev_level) begin
			m_repeats = m_repeats + 1;
			res.ev = EV_REPEAT;
		end else begin
			if (elapsed < DataW'(m_debounce)) begin
				m_spurious = m_spurious + 1;
				res.ev = EV_BOUNCE;
			end else if (lvl == m_match_level) begin
				m_matches = m_matches + 1;
				m_matched = 1'b1;
				res.ev = EV_MATCH;
			end else begin
				m_matched = 1'b0;
				if (m_max_matched == '0 || elapsed < m_max_matched) begin
					m_unmatches = m_unmatches + 1;
					m_duration = elapsed;
					res.ev = EV_UNMATCH;
				end else begin
					m_spurious = m_spurious + 1;
					res.ev = EV_OVERLONG;
				end
			end
			m_change_time = stamp;
			m_prev_level = lvl;
		end
		res.matched = m_matched;
		res.invoked = m_events;
		res.repeats = m_repeats;
		res.match_cnt = m_matches;
		res.unmatches = m_unmatches;
		res.spurious = m_spurious;
		res.duration = m_duration;
		return res;
	endfunction

	function automatic pin_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
			input logic [DataW-1:0] data);
		pin_row_t row;
		row = '{1'b1, idx, data, 1'b0, '0, '{1'b0, EV_REPEAT, 1'b0}};
		return row;
	endfunction

	function automatic pin_row_t item_row(input logic lvl, input logic [DataW-1:0] stamp,
			input logic typed, input event_t ev, input logic mat);
		pin_row_t row;
		row = '{1'b0, '0, '0, lvl, stamp, '{typed, ev, mat}};
		return row;
	endfunction

	task automatic check_field(input string name, input logic [DataW-1:0] want,
			input logic [DataW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data,
			input bit close_wr);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE: m_debounce = data[DebW-1:0];
			REG_MAX_MATCHED: m_max_matched = data;
			REG_MATCH_LEVEL: m_match_level = data[0];
			default: ;
		endcase
		if (close_wr) begin
			cfg_we <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (quals_checked != events_sent);
	endtask

	task automatic send_event(input logic lvl, input logic [DataW-1:0] stamp,
			input ev_tag_t tag);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		event_tags.push_back(tag);
		in_valid <= 1'b1;
		level <= lvl;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
		events_sent++;
	endtask

	task automatic run_phase(input logic [DataW-1:0] deb_word, input logic [DataW-1:0] max_word,
			input logic [DataW-1:0] lvl_word, input bit long_hold, input bit mid_pause);
		logic [DataW-1:0] delta;
		ev_tag_t plain_tag;
		plain_tag = '{1'b0, EV_REPEAT, 1'b0};
		wait_drained();
		reg_write(REG_DEBOUNCE, deb_word, 1'b0);
		if ($urandom_range(0, 2) == 0) begin
			reg_write(REG_UNUSED, $urandom, 1'b0);
		end
		reg_write(REG_MAX_MATCHED, max_word, 1'b0);
		reg_write(REG_MATCH_LEVEL, lvl_word, 1'b1);
		for (int i = 0; i < PHASE_EVENTS; i++) begin
			if (long_hold && i == 10) begin
				hold_req = 1'b1;
			end
			if (mid_pause && i == PHASE_EVENTS / 2) begin
				wait_drained();
			end
			// Most deltas land on or near the debounce and pulse-width limits.
			case ($urandom_range(0, 9))
				0, 1: delta = $urandom_range(0, m_debounce);
				2: delta = DataW'(m_debounce) - 1;
				3: delta = DataW'(m_debounce);
				4: delta = DataW'(m_debounce) + 1;
				5: delta = (m_max_matched != '0) ? m_max_matched - 1 + $urandom_range(0, 2)
					: $urandom;
				6: delta = $urandom;
				default: delta = DataW'(m_debounce) + $urandom_range(0, 300);
			endcase
			send_lvl = ($urandom_range(0, 4) == 0) ? send_lvl : ~send_lvl;
			send_stamp = send_stamp + delta;
			send_event(send_lvl, send_stamp, plain_tag);
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		qual_res_t want;
		qual_res_t res;
		ev_tag_t tag;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_quals.size() == 0) begin
					errors++;
					$display("%0t ns: result with no request pending, event_res %0h",
						$time, event_res);
				end else begin
					want = pending_quals.pop_front();
					check_field("event_res", DataW'(want.ev), DataW'(event_res));
					check_field("matched", DataW'(want.matched), DataW'(matched));
					check_field("invoked_count", want.invoked, invoked_count);
					check_field("repeat_count", want.repeats, repeat_count);
					check_field("match_count", want.match_cnt, match_count);
					check_field("unmatch_count", want.unmatches, unmatch_count);
					check_field("spurious_count", want.spurious, spurious_count);
					check_field("last_duration", want.duration, last_duration);
					quals_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				tag = (event_tags.size() != 0) ? event_tags.pop_front()
					: ev_tag_t'{1'b0, EV_REPEAT, 1'b0};
				res = qualify_event(level, now_ms);
				if (tag.typed) begin
					res.ev = tag.ev;
					res.matched = tag.matched;
				end
				pending_quals.push_back(res);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [DataW-1:0] deb_word;
		logic [DataW-1:0] max_word;
		logic [DataW-1:0] lvl_word;
		bit close_wr;

		// Reset settings: debounce 50, no pulse limit, matched level low.
		pin_table.push_back(item_row(1'b0, 32'h0000_0000, 1'b1, EV_REPEAT, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'h0000_000A, 1'b1, EV_BOUNCE, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0000_003C, 1'b1, EV_MATCH, 1'b1));
		pin_table.push_back(item_row(1'b0, 32'h0000_0064, 1'b1, EV_REPEAT, 1'b1));
		pin_table.push_back(item_row(1'b1, 32'h0000_00C8, 1'b1, EV_UNMATCH, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0000_00F9, 1'b1, EV_BOUNCE, 1'b0));
		// A release while already unmatched, then timestamps that wrap.
		pin_table.push_back(item_row(1'b1, 32'hFFFF_FFF0, 1'b1, EV_UNMATCH, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0000_0010, 1'b1, EV_BOUNCE, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'hFFFF_FFFF, 1'b1, EV_UNMATCH, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0000_0031, 1'b1, EV_MATCH, 1'b1));
		pin_table.push_back(cfg_row(REG_DEBOUNCE, 32'd0));
		pin_table.push_back(cfg_row(REG_MAX_MATCHED, 32'd100));
		pin_table.push_back(cfg_row(REG_MATCH_LEVEL, 32'd1));
		pin_table.push_back(item_row(1'b1, 32'h0000_0031, 1'b1, EV_MATCH, 1'b1));
		pin_table.push_back(item_row(1'b0, 32'h0000_0095, 1'b1, EV_OVERLONG, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'h0000_0096, 1'b0, EV_REPEAT, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0000_00F9, 1'b0, EV_REPEAT, 1'b0));
		// Largest settings; the upper data bits and the unused index must not matter.
		pin_table.push_back(cfg_row(REG_DEBOUNCE, 32'hFFFF_FFFF));
		pin_table.push_back(cfg_row(REG_MAX_MATCHED, 32'hFFFF_FFFF));
		pin_table.push_back(cfg_row(REG_MATCH_LEVEL, 32'hFFFF_FFFE));
		pin_table.push_back(cfg_row(REG_UNUSED, 32'h0000_0001));
		pin_table.push_back(item_row(1'b1, 32'h0001_00F7, 1'b1, EV_BOUNCE, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0002_00F6, 1'b1, EV_MATCH, 1'b1));
		pin_table.push_back(item_row(1'b1, 32'h0002_00F4, 1'b1, EV_UNMATCH, 1'b0));
		pin_table.push_back(item_row(1'b0, 32'h0003_00F3, 1'b0, EV_REPEAT, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'h0003_00F2, 1'b1, EV_OVERLONG, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'h0000_0000, 1'b1, EV_REPEAT, 1'b0));
		pin_table.push_back(cfg_row(REG_DEBOUNCE, 32'd0));
		pin_table.push_back(cfg_row(REG_MAX_MATCHED, 32'd0));
		pin_table.push_back(cfg_row(REG_MATCH_LEVEL, 32'd1));
		pin_table.push_back(item_row(1'b0, 32'h0003_00F2, 1'b1, EV_UNMATCH, 1'b0));
		pin_table.push_back(item_row(1'b1, 32'h0003_00F2, 1'b0, EV_REPEAT, 1'b0));
		// A new matched level leaves the matched state alone until the next change.
		pin_table.push_back(cfg_row(REG_MATCH_LEVEL, 32'd0));
		pin_table.push_back(item_row(1'b1, 32'h0003_00F2, 1'b1, EV_REPEAT, 1'b1));
		pin_table.push_back(item_row(1'b0, 32'h0003_00F3, 1'b1, EV_MATCH, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < pin_table.size(); i++) begin
			if (pin_table[i].is_cfg) begin
				if (i == 0 || !pin_table[i-1].is_cfg) begin
					wait_drained();
				end
				close_wr = (i + 1 == pin_table.size()) || !pin_table[i+1].is_cfg;
				reg_write(pin_table[i].idx, pin_table[i].data, close_wr);
			end else begin
				send_event(pin_table[i].lvl, pin_table[i].stamp, pin_table[i].tag);
			end
		end

		send_stamp = $urandom;
		for (int ph = 0; ph < 8; ph++) begin
			deb_word = $urandom;
			max_word = $urandom;
			lvl_word = $urandom;
			case (ph)
				0: begin
					deb_word[DebW-1:0] = '0;
					max_word = '0;
					lvl_word[0] = 1'b1;
				end
				1: begin
					deb_word[DebW-1:0] = '1;
					max_word = '1;
					lvl_word[0] = 1'b0;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: deb_word[DebW-1:0] = 16'd1;
						1: deb_word[DebW-1:0] = 16'd50;
						2: deb_word[DebW-1:0] = DebW'($urandom_range(0, 200));
						default: ;
					endcase
					case ($urandom_range(0, 2))
						0: max_word = '0;
						1: max_word = DataW'(deb_word[DebW-1:0]) + $urandom_range(0, 400);
						default: ;
					endcase
				end
			endcase
			if (ph == 7) begin
				idle_on = 1'b0;
				stall_on = 1'b0;
			end
			run_phase(deb_word, max_word, lvl_word, ph == 2, ph == 4);
		end

		in_valid <= 1'b0;
		while (quals_checked != events_sent) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_quals.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
